// ===== rtl/orb_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the overwriting ring buffer
package orb_pkg;

  localparam int unsigned DEFAULT_DEPTH = 64;
  localparam int unsigned CFG_W         = 7;
  localparam int unsigned WORD_W        = 16;
  localparam int unsigned POS_W         = 6;
  localparam int unsigned CNT_W         = 7;
  localparam int unsigned CMDQ_DEPTH    = 2;
  localparam int unsigned RSPQ_DEPTH    = 2;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(64);

  typedef enum logic [2:0] {
    REQ_ADD      = 3'd0,
    REQ_GET      = 3'd1,
    REQ_LATEST   = 3'd2,
    REQ_SET_HEAD = 3'd3,
    REQ_SET_TAIL = 3'd4,
    REQ_FILL     = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_GET,
    OP_LATEST,
    OP_SET_HEAD,
    OP_SET_TAIL,
    OP_FILL,
    OP_BAD
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GET_WAIT,
    ST_LAT_MOD,
    ST_LAT_RD,
    ST_LAT_EMIT,
    ST_FILL
  } st_e;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [WORD_W-1:0] data_in;
    logic [POS_W-1:0]  position;
    logic [CNT_W-1:0]  count;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] data_out;
    logic              ok;
    logic              last;
    logic              is_empty;
    logic              is_full;
  } rsp_t;

  typedef struct packed {
    op_e               op;
    logic [WORD_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  cnt;
    logic              pos_ok;
    logic              cnt_bad;
    logic              cnt_eq;
  } cmd_t;

endpackage

// ===== rtl/orb_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with registered read
module orb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/orb_fifo.sv =====
`timescale 1ns / 1ps
// small register queue with push/full and pop/empty sides
module orb_fifo #(
  parameter type         T     = logic,
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic pop_i,
  output T     rdata_o,
  output logic empty_o
);

  localparam int unsigned PW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  T               mem_q [Depth];
  logic [PW-1:0]  wptr_q, wptr_d;
  logic [PW-1:0]  rptr_q, rptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(Depth - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(Depth - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/orb_front.sv =====
`timescale 1ns / 1ps
// front end: decodes and range checks requests into the command queue
module orb_front #(
  parameter int unsigned DEPTH = orb_pkg::DEFAULT_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  orb_pkg::req_t              req_i,
  input  logic [$clog2(DEPTH+1)-1:0] size_i,
  input  logic                       cmd_pop_i,
  output orb_pkg::cmd_t              cmd_o,
  output logic                       cmd_empty_o
);

  orb_pkg::cmd_t cmd_w;

  always_comb begin
    cmd_w.data    = req_i.data_in;
    cmd_w.pos     = req_i.position;
    cmd_w.cnt     = req_i.count;
    cmd_w.pos_ok  = 32'(req_i.position) < 32'(size_i);
    cmd_w.cnt_bad = (req_i.count == '0) || (32'(req_i.count) > 32'(size_i));
    cmd_w.cnt_eq  = 32'(req_i.count) == 32'(size_i);
    unique case (req_i.req_type)
      orb_pkg::REQ_ADD:      cmd_w.op = orb_pkg::OP_ADD;
      orb_pkg::REQ_GET:      cmd_w.op = orb_pkg::OP_GET;
      orb_pkg::REQ_LATEST:   cmd_w.op = orb_pkg::OP_LATEST;
      orb_pkg::REQ_SET_HEAD: cmd_w.op = orb_pkg::OP_SET_HEAD;
      orb_pkg::REQ_SET_TAIL: cmd_w.op = orb_pkg::OP_SET_TAIL;
      orb_pkg::REQ_FILL:     cmd_w.op = orb_pkg::OP_FILL;
      default:               cmd_w.op = orb_pkg::OP_BAD;
    endcase
  end

  orb_fifo #(
    .T     (orb_pkg::cmd_t),
    .Depth (orb_pkg::CMDQ_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_w),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_o),
    .empty_o (cmd_empty_o)
  );

endmodule

// ===== rtl/orb_back.sv =====
`timescale 1ns / 1ps
// back end: ring indices, word store and result generation
module orb_back #(
  parameter int unsigned DEPTH = orb_pkg::DEFAULT_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [$clog2(DEPTH+1)-1:0] size_i,
  input  orb_pkg::cmd_t              cmd_i,
  input  logic                       cmd_empty_i,
  output logic                       cmd_pop_o,
  input  logic                       rsp_full_i,
  output logic                       rsp_push_o,
  output orb_pkg::rsp_t              rsp_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned AW = IW + 1;

  orb_pkg::st_e state_q, state_d;

  logic [IW-1:0]              wr_q, wr_d;
  logic [IW-1:0]              rd_q, rd_d;
  logic                       full_q, full_d;
  logic [DEPTH-1:0]           vld_q, vld_d;
  logic                       vld_rd_q;
  logic [AW-1:0]              mod_q, mod_d;
  logic [orb_pkg::CNT_W-1:0]  rem_q, rem_d;
  logic [IW-1:0]              fill_q, fill_d;

  logic                       ram_we;
  logic [IW-1:0]              ram_waddr;
  logic [orb_pkg::WORD_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [IW-1:0]              ram_raddr;
  logic [orb_pkg::WORD_W-1:0] ram_rdata;
  logic [orb_pkg::WORD_W-1:0] rd_word;

  logic                       empty_now;
  logic                       lat_fail;
  logic                       fill_last;
  logic [IW-1:0]              wr_adv, rd_adv;
  logic [AW-1:0]              lat_start;
  logic [AW-1:0]              size_a;

  function automatic logic [IW-1:0] adv(input logic [IW-1:0] idx,
                                        input logic [AW-1:0] sz);
    logic [AW-1:0] n;
    n = {1'b0, idx} + AW'(1);
    return (n >= sz) ? '0 : n[IW-1:0];
  endfunction

  assign size_a    = AW'(size_i);
  assign empty_now = !full_q && (wr_q == rd_q);
  assign wr_adv    = adv(wr_q, size_a);
  assign rd_adv    = adv(rd_q, size_a);
  assign lat_fail  = cmd_i.cnt_bad || (cmd_i.cnt_eq && !full_q);
  assign lat_start = AW'(wr_q) + size_a - AW'(cmd_i.cnt);
  assign fill_last = (AW'(fill_q) + AW'(1)) >= size_a;
  assign rd_word   = vld_rd_q ? ram_rdata : '0;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      orb_pkg::ST_IDLE: begin
        if (!cmd_empty_i) begin
          unique case (cmd_i.op)
            orb_pkg::OP_GET: begin
              if (!empty_now) state_d = orb_pkg::ST_GET_WAIT;
            end
            orb_pkg::OP_LATEST: begin
              if (!lat_fail) state_d = orb_pkg::ST_LAT_MOD;
            end
            orb_pkg::OP_FILL: state_d = orb_pkg::ST_FILL;
            default: state_d = orb_pkg::ST_IDLE;
          endcase
        end
      end
      orb_pkg::ST_GET_WAIT: begin
        if (!rsp_full_i) state_d = orb_pkg::ST_IDLE;
      end
      orb_pkg::ST_LAT_MOD: begin
        if (mod_q < size_a) state_d = orb_pkg::ST_LAT_RD;
      end
      orb_pkg::ST_LAT_RD: state_d = orb_pkg::ST_LAT_EMIT;
      orb_pkg::ST_LAT_EMIT: begin
        if (!rsp_full_i) begin
          state_d = (rem_q == orb_pkg::CNT_W'(1)) ? orb_pkg::ST_IDLE : orb_pkg::ST_LAT_RD;
        end
      end
      orb_pkg::ST_FILL: begin
        if (fill_last && !rsp_full_i) state_d = orb_pkg::ST_IDLE;
      end
      default: state_d = orb_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    wr_d       = wr_q;
    rd_d       = rd_q;
    full_d     = full_q;
    vld_d      = vld_q;
    mod_d      = mod_q;
    rem_d      = rem_q;
    fill_d     = fill_q;
    ram_we     = 1'b0;
    ram_waddr  = wr_q;
    ram_wdata  = cmd_i.data;
    ram_re     = 1'b0;
    ram_raddr  = rd_q;
    cmd_pop_o  = 1'b0;
    rsp_push_o = 1'b0;
    rsp_o      = '0;
    unique case (state_q)
      orb_pkg::ST_IDLE: begin
        if (!cmd_empty_i) begin
          unique case (cmd_i.op)
            orb_pkg::OP_ADD: begin
              if (!rsp_full_i) begin
                ram_we           = 1'b1;
                vld_d[wr_q]      = 1'b1;
                wr_d             = wr_adv;
                rd_d             = full_q ? rd_adv : rd_q;
                full_d           = (wr_adv == rd_d);
                rsp_o.ok         = 1'b1;
                rsp_o.last       = 1'b1;
                rsp_push_o       = 1'b1;
                cmd_pop_o        = 1'b1;
              end
            end
            orb_pkg::OP_GET: begin
              if (empty_now) begin
                if (!rsp_full_i) begin
                  rsp_o.last = 1'b1;
                  rsp_push_o = 1'b1;
                  cmd_pop_o  = 1'b1;
                end
              end else begin
                ram_re = 1'b1;
              end
            end
            orb_pkg::OP_LATEST: begin
              if (lat_fail) begin
                if (!rsp_full_i) begin
                  rsp_o.last = 1'b1;
                  rsp_push_o = 1'b1;
                  cmd_pop_o  = 1'b1;
                end
              end else begin
                mod_d = lat_start;
                rem_d = cmd_i.cnt;
              end
            end
            orb_pkg::OP_SET_HEAD: begin
              if (!rsp_full_i) begin
                if (cmd_i.pos_ok) wr_d = IW'(cmd_i.pos);
                rsp_o.ok   = cmd_i.pos_ok;
                rsp_o.last = 1'b1;
                rsp_push_o = 1'b1;
                cmd_pop_o  = 1'b1;
              end
            end
            orb_pkg::OP_SET_TAIL: begin
              if (!rsp_full_i) begin
                if (cmd_i.pos_ok) rd_d = IW'(cmd_i.pos);
                rsp_o.ok   = cmd_i.pos_ok;
                rsp_o.last = 1'b1;
                rsp_push_o = 1'b1;
                cmd_pop_o  = 1'b1;
              end
            end
            orb_pkg::OP_FILL: fill_d = '0;
            default: begin
              if (!rsp_full_i) begin
                rsp_o.last = 1'b1;
                rsp_push_o = 1'b1;
                cmd_pop_o  = 1'b1;
              end
            end
          endcase
        end
      end
      orb_pkg::ST_GET_WAIT: begin
        if (!rsp_full_i) begin
          rd_d           = rd_adv;
          full_d         = 1'b0;
          rsp_o.data_out = rd_word;
          rsp_o.ok       = 1'b1;
          rsp_o.last     = 1'b1;
          rsp_push_o     = 1'b1;
          cmd_pop_o      = 1'b1;
        end
      end
      orb_pkg::ST_LAT_MOD: begin
        if (mod_q >= size_a) begin
          mod_d = mod_q - size_a;
        end else begin
          rd_d = mod_q[IW-1:0];
        end
      end
      orb_pkg::ST_LAT_RD: ram_re = 1'b1;
      orb_pkg::ST_LAT_EMIT: begin
        if (!rsp_full_i) begin
          rd_d           = rd_adv;
          full_d         = 1'b0;
          rem_d          = rem_q - orb_pkg::CNT_W'(1);
          rsp_o.data_out = rd_word;
          rsp_o.ok       = 1'b1;
          rsp_o.last     = (rem_q == orb_pkg::CNT_W'(1));
          rsp_push_o     = 1'b1;
          cmd_pop_o      = (rem_q == orb_pkg::CNT_W'(1));
        end
      end
      orb_pkg::ST_FILL: begin
        ram_waddr = fill_q;
        if (!fill_last) begin
          ram_we        = 1'b1;
          vld_d[fill_q] = 1'b1;
          fill_d        = fill_q + IW'(1);
        end else if (!rsp_full_i) begin
          ram_we        = 1'b1;
          vld_d[fill_q] = 1'b1;
          wr_d          = '0;
          rd_d          = '0;
          full_d        = 1'b0;
          rsp_o.ok      = 1'b1;
          rsp_o.last    = 1'b1;
          rsp_push_o    = 1'b1;
          cmd_pop_o     = 1'b1;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
    rsp_o.is_full  = full_d;
    rsp_o.is_empty = !full_d && (wr_d == rd_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= orb_pkg::ST_IDLE;
      wr_q    <= '0;
      rd_q    <= '0;
      full_q  <= 1'b0;
      vld_q   <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      full_q  <= full_d;
      vld_q   <= vld_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mod_q  <= mod_d;
    fill_q <= fill_d;
    if (ram_re) begin
      vld_rd_q <= vld_q[ram_raddr];
    end
  end

  orb_ram #(
    .WIDTH (orb_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== rtl/overwriting_ring_buffer_top.sv =====
`timescale 1ns / 1ps
// top level of the overwriting ring buffer
//
// requests enter through push/full: a word is taken when push is high and
// full is low. every request yields one or more result words, read through
// empty/pop: the oldest result sits on rsp_o while empty is low and leaves
// when pop is high. cfg_we_i writes size_in_use from cfg_wdata_i; write it
// only while no request is in flight.
// an add, set head/tail or failed request is answered by the command engine
// straight from idle; a get reads the store and then returns the registered
// word; a get latest rewinds the read index, taking size_in_use off it while
// it is not below size_in_use (at most once unless the size shrank below the
// write index), then reads and returns each word in turn; reset fill writes
// each of the size_in_use entries in turn. the engine works on one command
// at a time and takes the next only when the last is done.
// a two-entry command queue and a two-entry result queue part the sides;
// when the receiver stalls the engine waits and the command queue fills.
// reset clears indices, full mark, entry valid bits and both queues, so
// the store reads as zero, and sets size_in_use to 64.
module overwriting_ring_buffer_top #(
  parameter int unsigned DEPTH = orb_pkg::DEFAULT_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [orb_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      push,
  output logic                      full,
  input  orb_pkg::req_t             req_i,
  output logic                      empty,
  input  logic                      pop,
  output orb_pkg::rsp_t             rsp_o
);

  localparam int unsigned SW = $clog2(DEPTH + 1);

  logic [orb_pkg::CFG_W-1:0] cfg_q;
  logic [SW-1:0]             size_w;
  orb_pkg::cmd_t             cmd_w;
  logic                      cmd_empty;
  logic                      cmd_pop;
  logic                      rsp_full;
  logic                      rsp_push;
  orb_pkg::rsp_t             rsp_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= orb_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // effective size, clamped to 1..DEPTH
  always_comb begin
    if (cfg_q == '0) begin
      size_w = SW'(1);
    end else if (32'(cfg_q) > 32'(DEPTH)) begin
      size_w = SW'(DEPTH);
    end else begin
      size_w = SW'(cfg_q);
    end
  end

  orb_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .size_i      (size_w),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd_w),
    .cmd_empty_o (cmd_empty)
  );

  orb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .size_i      (size_w),
    .cmd_i       (cmd_w),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .rsp_full_i  (rsp_full),
    .rsp_push_o  (rsp_push),
    .rsp_o       (rsp_w)
  );

  orb_fifo #(
    .T     (orb_pkg::rsp_t),
    .Depth (orb_pkg::RSPQ_DEPTH)
  ) u_rsp_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rsp_push),
    .wdata_i (rsp_w),
    .full_o  (rsp_full),
    .pop_i   (pop),
    .rdata_o (rsp_o),
    .empty_o (empty)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) rsp_push |-> !rsp_full)
    else $error("result word pushed into a full result queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> !cmd_empty && rsp_push)
    else $error("command retired without a result word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   rsp_push |-> !(rsp_w.is_empty && rsp_w.is_full))
    else $error("result word reports empty and full together");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   rsp_push && !rsp_w.ok |-> rsp_w.data_out == '0 && rsp_w.last)
    else $error("failed result word carries data or is not last");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// testbench of the overwriting ring buffer: random and directed requests, scoreboard check
module tb_top;
  import orb_pkg::*;

  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned RAND_PER_PHASE = 16;

  class ring_scoreboard;
    logic [CFG_W-1:0]  size_cfg;
    logic [WORD_W-1:0] ring [DEFAULT_DEPTH];
    logic [POS_W-1:0]  wr_idx;
    logic [POS_W-1:0]  rd_idx;
    logic              full_flag;
    rsp_t              exp_rsp [$];
    int unsigned       mismatches;
    int unsigned       n_requests;
    int unsigned       n_results;

    function new();
      size_cfg = SIZE_RESET;
      foreach (ring[k]) ring[k] = '0;
      wr_idx = '0;
      rd_idx = '0;
      full_flag = 1'b0;
      mismatches = 0;
      n_requests = 0;
      n_results = 0;
    endfunction

    function int unsigned eff_size();
      if (size_cfg == 0) return 1;
      if (size_cfg > DEFAULT_DEPTH) return DEFAULT_DEPTH;
      return size_cfg;
    endfunction

    function logic [POS_W-1:0] step_idx(logic [POS_W-1:0] idx);
      int unsigned n;
      n = idx + 1;
      return (n >= eff_size()) ? '0 : POS_W'(n);
    endfunction

    function logic ring_empty();
      return !full_flag && wr_idx == rd_idx;
    endfunction

    function void emit(logic [WORD_W-1:0] word, logic ok, logic last);
      rsp_t r;
      r.data_out = word;
      r.ok = ok;
      r.last = last;
      r.is_empty = ring_empty();
      r.is_full = full_flag;
      exp_rsp.push_back(r);
    endfunction

    function void note_request(req_t r);
      int unsigned sz;
      logic        was_full;
      logic [WORD_W-1:0] word;
      sz = eff_size();
      n_requests++;
      case (r.req_type)
        REQ_ADD: begin
          was_full = full_flag;
          ring[wr_idx] = r.data_in;
          wr_idx = step_idx(wr_idx);
          if (was_full) rd_idx = step_idx(rd_idx);
          full_flag = (wr_idx == rd_idx);
          emit('0, 1'b1, 1'b1);
        end
        REQ_GET: begin
          if (ring_empty()) begin
            emit('0, 1'b0, 1'b1);
          end else begin
            word = ring[rd_idx];
            rd_idx = step_idx(rd_idx);
            full_flag = 1'b0;
            emit(word, 1'b1, 1'b1);
          end
        end
        REQ_LATEST: begin
          if (r.count == 0 || r.count > sz || (r.count == sz && !full_flag)) begin
            emit('0, 1'b0, 1'b1);
          end else begin
            rd_idx = POS_W'((int'(wr_idx) + sz - int'(r.count)) % sz);
            for (int k = 0; k < r.count; k++) begin
              word = ring[rd_idx];
              rd_idx = step_idx(rd_idx);
              full_flag = 1'b0;
              emit(word, 1'b1, k + 1 == r.count);
            end
          end
        end
        REQ_SET_HEAD, REQ_SET_TAIL: begin
          if (r.position < sz) begin
            if (r.req_type == REQ_SET_HEAD) wr_idx = r.position;
            else rd_idx = r.position;
            emit('0, 1'b1, 1'b1);
          end else begin
            emit('0, 1'b0, 1'b1);
          end
        end
        REQ_FILL: begin
          for (int k = 0; k < sz; k++) ring[k] = r.data_in;
          wr_idx = '0;
          rd_idx = '0;
          full_flag = 1'b0;
          emit('0, 1'b1, 1'b1);
        end
        default: emit('0, 1'b0, 1'b1);
      endcase
    endfunction

    function void flag(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      n_results++;
      if (exp_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: unexpected word, expected none, got %0h", $time, got);
        return;
      end
      want = exp_rsp.pop_front();
      if (got.data_out !== want.data_out) flag("data_out", want.data_out, got.data_out);
      if (got.ok !== want.ok) flag("ok", want.ok, got.ok);
      if (got.last !== want.last) flag("last", want.last, got.last);
      if (got.is_empty !== want.is_empty) flag("is_empty", want.is_empty, got.is_empty);
      if (got.is_full !== want.is_full) flag("is_full", want.is_full, got.is_full);
    endfunction

    function int unsigned pending();
      return exp_rsp.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             push = 1'b0;
  logic             full;
  req_t             req = '0;
  logic             empty;
  logic             pop = 1'b0;
  rsp_t             rsp;
  logic             idle_en = 1'b1;
  int unsigned      rx_hold = 0;
  ring_scoreboard   board = new();

  overwriting_ring_buffer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .push        (push),
    .full        (full),
    .req_i       (req),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result side: check the word taken at this edge, then decide on a stall
  always @(posedge clk_i) begin
    if (pop && !empty) board.check_result(rsp);
    if (rx_hold != 0) begin
      rx_hold--;
      pop <= 1'b0;
    end else if (idle_en && $urandom_range(0, 11) == 0) begin
      rx_hold = $urandom_range(0, 15);
      pop <= 1'b0;
    end else begin
      pop <= rst_n;
    end
  end

  function automatic req_t mk_req(logic [2:0] kind, logic [WORD_W-1:0] word,
                                  logic [POS_W-1:0] pos, logic [CNT_W-1:0] cnt);
    req_t r;
    r.req_type = kind;
    r.data_in = word;
    r.position = pos;
    r.count = cnt;
    return r;
  endfunction

  function automatic req_t random_req(int unsigned sz);
    req_t r;
    int unsigned pick;
    r = mk_req(REQ_ADD, WORD_W'($urandom), POS_W'($urandom), CNT_W'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 35) r.req_type = REQ_ADD;
    else if (pick < 55) r.req_type = REQ_GET;
    else if (pick < 72) r.req_type = REQ_LATEST;
    else if (pick < 80) r.req_type = REQ_SET_HEAD;
    else if (pick < 88) r.req_type = REQ_SET_TAIL;
    else if (pick < 94) r.req_type = REQ_FILL;
    else if (pick < 97) r.req_type = REQ_SPARE_LO;
    else r.req_type = REQ_SPARE_HI;
    pick = $urandom_range(0, 9);
    if (pick < 7) r.count = CNT_W'($urandom_range(1, sz));
    else if (pick == 7) r.count = CNT_W'(sz);
    else if (pick == 8) r.count = '0;
    if ($urandom_range(0, 9) < 8) r.position = POS_W'($urandom_range(0, sz - 1));
    return r;
  endfunction

  task automatic send_req(req_t r);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    push <= 1'b1;
    req <= r;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    board.note_request(r);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_size(logic [CFG_W-1:0] value);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    board.size_cfg = value;
  endtask

  initial begin
    logic [CFG_W-1:0] sizes [NUM_PHASES];
    int unsigned sz;
    sizes = '{CFG_W'(8), CFG_W'(1), CFG_W'(0), CFG_W'(3),
              CFG_W'(64), CFG_W'(127), CFG_W'(16), CFG_W'(5)};
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed part on a four-entry ring
    set_size(CFG_W'(4));
    send_req(mk_req(REQ_GET, 16'h0000, '0, '0));
    send_req(mk_req(REQ_LATEST, 16'h0000, '0, 7'd0));
    send_req(mk_req(REQ_ADD, 16'h0000, '0, '0));
    send_req(mk_req(REQ_ADD, 16'hffff, 6'h3f, 7'h7f));
    send_req(mk_req(REQ_LATEST, 16'h0000, '0, 7'd2));
    send_req(mk_req(REQ_LATEST, 16'h0000, '0, 7'd4));
    send_req(mk_req(REQ_LATEST, 16'h0000, '0, 7'd127));
    send_req(mk_req(REQ_SET_HEAD, 16'h0000, 6'd3, '0));
    send_req(mk_req(REQ_SET_HEAD, 16'h0000, 6'd4, '0));
    send_req(mk_req(REQ_SET_TAIL, 16'h0000, 6'd63, '0));
    send_req(mk_req(REQ_SET_TAIL, 16'h0000, 6'd0, '0));
    send_req(mk_req(REQ_SPARE_LO, 16'h1234, '0, '0));
    send_req(mk_req(REQ_SPARE_HI, 16'h4321, '0, '0));
    send_req(mk_req(REQ_FILL, 16'hffff, '0, '0));
    for (int k = 1; k <= 5; k++) send_req(mk_req(REQ_ADD, WORD_W'(k * 16'h1111), '0, '0));
    send_req(mk_req(REQ_LATEST, 16'h0000, '0, 7'd4));
    send_req(mk_req(REQ_GET, 16'h0000, '0, '0));
    send_req(mk_req(REQ_ADD, 16'h8001, '0, '0));
    send_req(mk_req(REQ_LATEST, 16'h0000, '0, 7'd1));
    send_req(mk_req(REQ_GET, 16'h0000, '0, '0));
    send_req(mk_req(REQ_FILL, 16'h0000, '0, '0));

    // random part, one size setting per phase, wrap and overwrite first
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) idle_en = 1'b0;
      set_size(sizes[p]);
      sz = board.eff_size();
      for (int k = 0; k < sz + 2; k++)
        send_req(mk_req(REQ_ADD, WORD_W'($urandom), POS_W'($urandom), CNT_W'($urandom)));
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        if (p == 2 && k == RAND_PER_PHASE / 2) drain();
        send_req(random_req(sz));
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (board.pending() != 0) begin
      board.mismatches++;
      $display("%0t: %0d expected words never arrived", $time, board.pending());
    end
    $display("covered %0d requests and %0d result words over %0d size settings",
             board.n_requests, board.n_results, NUM_PHASES + 1);
    $display("with random stalls on both sides and a stall-free last phase");
    if (board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout at %0t", $time);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/orb_pkg.sv
rtl/orb_ram.sv
rtl/orb_fifo.sv
rtl/orb_front.sv
rtl/orb_back.sv
rtl/overwriting_ring_buffer_top.sv
sim/tb_top.sv
